// ===== rtl/core/xed_pkg.sv =====
// xed_pkg: shared types, character codes and entity tables for the entity decoder.
// Used by xed_datapath, xed_ctrl and xml_entity_decoder; depends on nothing.
`default_nettype none

package xed_pkg;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_AMP  = 2'd1,
    MODE_NAME = 2'd2,
    MODE_NUM  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_AMP  = 2'd0,
    KIND_GT   = 2'd1,
    KIND_LT   = 2'd2,
    KIND_QUOT = 2'd3
  } kind_t;

  // output register source select
  typedef enum logic [1:0] {
    SRC_DECODE = 2'd0,
    SRC_PLAN   = 2'd1,
    SRC_PEND   = 2'd2
  } src_t;

  localparam logic [7:0] CH_AMP  = 8'h26;  // &
  localparam logic [7:0] CH_HASH = 8'h23;  // #
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_A    = 8'h61;
  localparam logic [7:0] CH_G    = 8'h67;
  localparam logic [7:0] CH_L    = 8'h6C;
  localparam logic [7:0] CH_Q    = 8'h71;

  typedef struct packed {
    logic take;        // latch the decode plan of the accepted byte
    logic commit;      // apply the decoded state update in place
    logic apply;       // apply the latched mode after a flush
    logic clear_mode;  // end-of-text flush done
    logic slot_clear;
    logic slot_inc;
    logic load;        // load output register
    src_t src;
    logic last;
    logic tend;
  } cmd_t;

  typedef struct packed {
    logic dec_flush;
    logic dec_emit;
    logic dec_newpend;
    logic p_emit;
    logic p_newpend;
    logic p_end;
    logic slot_last;
    logic out_free;
  } sts_t;

  // entity name text after the ampersand, zero past its end
  function automatic logic [7:0] ent_text(input kind_t kind, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (kind)
      KIND_AMP: begin
        unique case (pos)
          3'd0: c = 8'h61;
          3'd1: c = 8'h6D;
          3'd2: c = 8'h70;
          3'd3: c = CH_SEMI;
          default: c = 8'h00;
        endcase
      end
      KIND_GT: begin
        unique case (pos)
          3'd0: c = 8'h67;
          3'd1: c = 8'h74;
          3'd2: c = CH_SEMI;
          default: c = 8'h00;
        endcase
      end
      KIND_LT: begin
        unique case (pos)
          3'd0: c = 8'h6C;
          3'd1: c = 8'h74;
          3'd2: c = CH_SEMI;
          default: c = 8'h00;
        endcase
      end
      KIND_QUOT: begin
        unique case (pos)
          3'd0: c = 8'h71;
          3'd1: c = 8'h75;
          3'd2: c = 8'h6F;
          3'd3: c = 8'h74;
          3'd4: c = CH_SEMI;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic logic [2:0] ent_len(input kind_t kind);
    logic [2:0] n;
    unique case (kind)
      KIND_AMP:  n = 3'd4;
      KIND_GT:   n = 3'd3;
      KIND_LT:   n = 3'd3;
      KIND_QUOT: n = 3'd5;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] ent_char(input kind_t kind);
    logic [7:0] c;
    unique case (kind)
      KIND_AMP:  c = CH_AMP;
      KIND_GT:   c = 8'h3E;
      KIND_LT:   c = 8'h3C;
      KIND_QUOT: c = 8'h22;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/xed_datapath.sv =====
// xed_datapath: entity match state, digit store, decode plan, pending-byte replay
// and the output register. Depends on xed_pkg; driven by xed_ctrl commands.
`default_nettype none

module xed_datapath #(
  parameter int MAX_DIGITS = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_wr_en,
  input  wire logic         cfg_wr_data,
  input  wire logic [7:0]   in_byte,
  input  wire logic         in_end,
  input  wire xed_pkg::cmd_t cmd,
  output xed_pkg::sts_t     sts,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              out_last,
  output logic              out_tend,
  input  wire logic         out_ready
);

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W  = $clog2(MAX_DIGITS);
  localparam int SLOT_W = $clog2(MAX_DIGITS + 2);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DIGITS);

  logic                 decode_enable;
  xed_pkg::mode_t       mode;
  xed_pkg::kind_t       kind;
  logic [2:0]           name_pos;
  logic [3:0]           digit_store [MAX_DIGITS];
  logic [CNT_W-1:0]     digit_count;
  logic [7:0]           value_acc;
  logic [SLOT_W-1:0]    slot;

  xed_pkg::mode_t       p_mode;
  logic                 p_emit;
  logic [7:0]           p_byte;
  logic                 p_end;

  // decode of the incoming byte against the current state
  xed_pkg::mode_t       mode_next;
  xed_pkg::kind_t       kind_next;
  logic [2:0]           name_pos_next;
  logic [CNT_W-1:0]     digit_count_next;
  logic [7:0]           value_acc_next;
  logic                 dig_we;
  logic                 flush_old;
  logic                 emit;
  logic [7:0]           emit_byte;
  logic                 is_digit;
  xed_pkg::mode_t       idle_mode;
  logic                 idle_emit;

  always_comb begin
    mode_next        = mode;
    kind_next        = kind;
    name_pos_next    = name_pos;
    digit_count_next = digit_count;
    value_acc_next   = value_acc;
    dig_we           = 1'b0;
    flush_old        = 1'b0;
    emit             = 1'b0;
    emit_byte        = in_byte;
    is_digit  = (in_byte >= xed_pkg::CH_ZERO) && (in_byte <= xed_pkg::CH_NINE);
    idle_mode = (in_byte == xed_pkg::CH_AMP) ? xed_pkg::MODE_AMP : xed_pkg::MODE_IDLE;
    idle_emit = (in_byte != xed_pkg::CH_AMP);
    if (!decode_enable) begin
      flush_old = (mode != xed_pkg::MODE_IDLE);
      emit      = 1'b1;
      mode_next = xed_pkg::MODE_IDLE;
    end else begin
      unique case (mode)
        xed_pkg::MODE_IDLE: begin
          mode_next = idle_mode;
          emit      = idle_emit;
        end
        xed_pkg::MODE_AMP: begin
          if (in_byte == xed_pkg::CH_A || in_byte == xed_pkg::CH_G ||
              in_byte == xed_pkg::CH_L || in_byte == xed_pkg::CH_Q) begin
            kind_next = (in_byte == xed_pkg::CH_A) ? xed_pkg::KIND_AMP :
                        (in_byte == xed_pkg::CH_G) ? xed_pkg::KIND_GT :
                        (in_byte == xed_pkg::CH_L) ? xed_pkg::KIND_LT : xed_pkg::KIND_QUOT;
            name_pos_next = 3'd1;
            mode_next     = xed_pkg::MODE_NAME;
          end else if (in_byte == xed_pkg::CH_HASH) begin
            digit_count_next = '0;
            value_acc_next   = '0;
            mode_next        = xed_pkg::MODE_NUM;
          end else begin
            flush_old = 1'b1;
            emit      = 1'b1;
            mode_next = xed_pkg::MODE_IDLE;
          end
        end
        xed_pkg::MODE_NAME: begin
          if (in_byte == xed_pkg::ent_text(kind, name_pos)) begin
            name_pos_next = name_pos + 3'd1;
            if (name_pos + 3'd1 == xed_pkg::ent_len(kind)) begin
              emit      = 1'b1;
              emit_byte = xed_pkg::ent_char(kind);
              mode_next = xed_pkg::MODE_IDLE;
            end
          end else begin
            flush_old = 1'b1;
            mode_next = idle_mode;
            emit      = idle_emit;
          end
        end
        xed_pkg::MODE_NUM: begin
          if (is_digit) begin
            if (digit_count < CNT_MAX) begin
              dig_we           = 1'b1;
              digit_count_next = digit_count + CNT_W'(1);
              // acc*10 + digit, mod 256
              value_acc_next   = {value_acc[4:0], 3'b000} + {value_acc[6:0], 1'b0}
                                 + {4'b0000, in_byte[3:0]};
            end else begin
              flush_old = 1'b1;
              emit      = 1'b1;
              mode_next = xed_pkg::MODE_IDLE;
            end
          end else if (in_byte == xed_pkg::CH_SEMI && digit_count != '0) begin
            emit      = 1'b1;
            emit_byte = value_acc;
            mode_next = xed_pkg::MODE_IDLE;
          end else begin
            flush_old = 1'b1;
            mode_next = idle_mode;
            emit      = idle_emit;
          end
        end
      endcase
    end
  end

  // replay of the pending bytes of the current state, one slot per transfer
  logic [SLOT_W-1:0] slot_m1;
  logic [SLOT_W-1:0] slot_m2;
  logic [SLOT_W-1:0] pend_last_idx;
  logic [7:0]        pend_byte;

  always_comb begin
    slot_m1 = slot - SLOT_W'(1);
    slot_m2 = slot - SLOT_W'(2);
    unique case (mode)
      xed_pkg::MODE_NAME: begin
        pend_last_idx = SLOT_W'(name_pos);
        pend_byte = (slot == '0) ? xed_pkg::CH_AMP : xed_pkg::ent_text(kind, slot_m1[2:0]);
      end
      xed_pkg::MODE_NUM: begin
        pend_last_idx = SLOT_W'(digit_count) + SLOT_W'(1);
        if (slot == '0) begin
          pend_byte = xed_pkg::CH_AMP;
        end else if (slot == SLOT_W'(1)) begin
          pend_byte = xed_pkg::CH_HASH;
        end else begin
          pend_byte = xed_pkg::CH_ZERO | {4'b0000, digit_store[slot_m2[IDX_W-1:0]]};
        end
      end
      default: begin
        pend_last_idx = '0;
        pend_byte     = xed_pkg::CH_AMP;
      end
    endcase
  end

  always_comb begin
    sts.dec_flush   = flush_old;
    sts.dec_emit    = emit;
    sts.dec_newpend = (mode_next != xed_pkg::MODE_IDLE);
    sts.p_emit      = p_emit;
    sts.p_newpend   = (p_mode != xed_pkg::MODE_IDLE);
    sts.p_end       = p_end;
    sts.slot_last   = (slot == pend_last_idx);
    sts.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decode_enable <= 1'b1;
      mode          <= xed_pkg::MODE_IDLE;
      kind          <= xed_pkg::KIND_AMP;
      name_pos      <= '0;
      digit_count   <= '0;
      value_acc     <= '0;
      slot          <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        decode_enable <= cfg_wr_data;
      end
      if (cmd.commit) begin
        mode        <= mode_next;
        kind        <= kind_next;
        name_pos    <= name_pos_next;
        digit_count <= digit_count_next;
        value_acc   <= value_acc_next;
      end else if (cmd.apply) begin
        mode <= p_mode;
      end else if (cmd.clear_mode) begin
        mode <= xed_pkg::MODE_IDLE;
      end
      if (cmd.slot_clear) begin
        slot <= '0;
      end else if (cmd.slot_inc) begin
        slot <= slot + SLOT_W'(1);
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      p_mode <= mode_next;
      p_emit <= emit;
      p_byte <= emit_byte;
      p_end  <= in_end;
    end
    if (cmd.commit && dig_we) begin
      digit_store[digit_count[IDX_W-1:0]] <= in_byte[3:0];
    end
    if (cmd.load) begin
      unique case (cmd.src)
        xed_pkg::SRC_DECODE: out_byte <= emit_byte;
        xed_pkg::SRC_PLAN:   out_byte <= p_byte;
        default:             out_byte <= pend_byte;
      endcase
      out_last <= cmd.last;
      out_tend <= cmd.tend;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/xed_ctrl.sv =====
// xed_ctrl: sequencer for accept, replay of pending bytes and end-of-text flush.
// Depends on xed_pkg; commands xed_datapath through cmd_t, reads sts_t.
`default_nettype none

module xed_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  input  wire logic          s_tlast,
  output logic               s_tready,
  input  wire xed_pkg::sts_t sts,
  output xed_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_RUN  = 2'd0,  // accepting bytes
    ST_OLD  = 2'd1,  // replaying the pending bytes of a failed match
    ST_MID  = 2'd2,  // byte handled afresh after the replay
    ST_ENDF = 2'd3   // end-of-text flush
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = (state == ST_RUN) && sts.out_free;
    accept     = s_tvalid && s_tready;
    unique case (state)
      ST_RUN: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (sts.dec_flush) begin
            cmd.slot_clear = 1'b1;
            state_next     = ST_OLD;
          end else begin
            cmd.commit = 1'b1;
            if (sts.dec_emit) begin
              cmd.load = 1'b1;
              cmd.src  = xed_pkg::SRC_DECODE;
              cmd.last = !(s_tlast && sts.dec_newpend);
              cmd.tend = s_tlast && !sts.dec_newpend;
            end
            if (s_tlast && sts.dec_newpend) begin
              cmd.slot_clear = 1'b1;
              state_next     = ST_ENDF;
            end
          end
        end
      end
      ST_OLD: begin
        if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.src      = xed_pkg::SRC_PEND;
          cmd.slot_inc = 1'b1;
          if (sts.slot_last) begin
            cmd.last   = !sts.p_emit && !(sts.p_end && sts.p_newpend);
            cmd.tend   = !sts.p_emit && !sts.p_newpend && sts.p_end;
            state_next = ST_MID;
          end
        end
      end
      ST_MID: begin
        if (!sts.p_emit || sts.out_free) begin
          cmd.apply = 1'b1;
          if (sts.p_emit) begin
            cmd.load = 1'b1;
            cmd.src  = xed_pkg::SRC_PLAN;
            cmd.last = !(sts.p_end && sts.p_newpend);
            cmd.tend = sts.p_end && !sts.p_newpend;
          end
          if (sts.p_end && sts.p_newpend) begin
            cmd.slot_clear = 1'b1;
            state_next     = ST_ENDF;
          end else begin
            state_next = ST_RUN;
          end
        end
      end
      ST_ENDF: begin
        if (sts.out_free) begin
          cmd.load     = 1'b1;
          cmd.src      = xed_pkg::SRC_PEND;
          cmd.slot_inc = 1'b1;
          if (sts.slot_last) begin
            cmd.last       = 1'b1;
            cmd.tend       = 1'b1;
            cmd.clear_mode = 1'b1;
            state_next     = ST_RUN;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> sts.out_free)
    else $error("output register loaded while occupied");

  a_tend_last: assert property (@(posedge clk) disable iff (rst)
    cmd.tend |-> cmd.last)
    else $error("text end without run end");

  a_flush_stalls: assert property (@(posedge clk) disable iff (rst)
    (accept && sts.dec_flush) |=> !s_tready)
    else $error("input taken during replay");

  a_tend_run: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && cmd.tend) |=> (state == ST_RUN))
    else $error("sequencer busy after text end");

endmodule

`default_nettype wire

// ===== rtl/core/xml_entity_decoder.sv =====
// xml_entity_decoder: top level of the XML character entity decoder.
// Depends on xed_pkg, xed_datapath and xed_ctrl.
//
//   channel   dir  tdata               tuser      tlast
//   s_axis    in   [7:0] in_byte       -          in_end
//   m_axis    out  [7:0] out_byte      run_last   text_end
//   cfg       in   decode_enable (cfg_wr_data), write on cfg_wr_en
//
// A byte that needs no replay is handled without leaving ST_RUN; results go through one output register.
// A failed match replays its k pending bytes at one per cycle while the output is free, then handles the byte afresh.
// End of text with k pending bytes flushes them to the output.
// Reset: decoding on, idle; the digit store is not cleared.
// m_tready low holds the output register and every sequencer step that loads it; input waits meanwhile.
`default_nettype none

module xml_entity_decoder #(
  parameter int MAX_DIGITS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,   // decode_enable
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,       // [7:0] in_byte
  input  wire logic       s_tlast,       // in_end
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,       // [7:0] out_byte
  output logic            m_tuser,       // [0] run_last
  output logic            m_tlast        // text_end
);

  xed_pkg::cmd_t cmd;
  xed_pkg::sts_t sts;

  xed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xed_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_byte     (s_tdata),
    .in_end      (s_tlast),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_tvalid),
    .out_byte    (m_tdata),
    .out_last    (m_tuser),
    .out_tend    (m_tlast),
    .out_ready   (m_tready)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking bench for xml_entity_decoder, driven over its stream ports.
// A predictor of the entity decoding feeds a queue of expected output bytes.
// Depends on xed_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb;

  localparam int MAX_DIG = 8;
  localparam int SETTLE  = 2 * MAX_DIG + 8;   // cycles for a replay or flush to finish

  localparam int RX_FREE  = 0;   // always ready
  localparam int RX_COIN  = 1;   // ready at random
  localparam int RX_BURST = 2;   // alternating ready and stall runs

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       text_end;
  } dec_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tuser;
  logic       m_tlast;

  xml_entity_decoder #(.MAX_DIGITS(MAX_DIG)) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // decoder shadow state
  string            ent_name [4] = '{"amp;", "gt;", "lt;", "quot;"};
  logic [7:0]       ent_glyph [4] = '{8'h26, 8'h3E, 8'h3C, 8'h22};
  logic             decode_on = 1'b1;
  xed_pkg::mode_t   dec_mode = xed_pkg::MODE_IDLE;
  xed_pkg::kind_t   ent_kind = xed_pkg::KIND_AMP;
  int               name_idx = 0;
  logic [3:0]       digit_buf [MAX_DIG];
  int               digit_cnt = 0;
  logic [7:0]       num_val = 8'h00;

  dec_out_t   expected_q[$];
  dec_out_t   step_q[$];
  int         mismatch_cnt = 0;

  // stimulus pacing
  bit         tx_idle = 1'b1;
  int         burst_left = 0;
  int         rx_mode = RX_FREE;
  int         rx_hold = 0;
  bit         rx_stall = 1'b0;

  function automatic void emit(input logic [7:0] b);
    step_q.push_back({b, 2'b00});
  endfunction

  // replay whatever partial entity is held
  function automatic void flush_pending();
    string s;
    s = ent_name[int'(ent_kind)];
    case (dec_mode)
      xed_pkg::MODE_AMP: emit(xed_pkg::CH_AMP);
      xed_pkg::MODE_NAME: begin
        emit(xed_pkg::CH_AMP);
        for (int i = 0; i < name_idx && i < s.len(); i++) emit(s[i]);
      end
      xed_pkg::MODE_NUM: begin
        emit(xed_pkg::CH_AMP);
        emit(xed_pkg::CH_HASH);
        for (int i = 0; i < digit_cnt && i < MAX_DIG; i++) begin
          emit(xed_pkg::CH_ZERO + digit_buf[i]);
        end
      end
      default: ;
    endcase
    dec_mode = xed_pkg::MODE_IDLE;
  endfunction

  function automatic void idle_byte(input logic [7:0] b);
    if (b == xed_pkg::CH_AMP) dec_mode = xed_pkg::MODE_AMP;
    else emit(b);
  endfunction

  function automatic void decode_byte(input logic [7:0] b);
    string s;
    s = ent_name[int'(ent_kind)];
    case (dec_mode)
      xed_pkg::MODE_IDLE: idle_byte(b);
      xed_pkg::MODE_AMP: begin
        if (b == xed_pkg::CH_A || b == xed_pkg::CH_G ||
            b == xed_pkg::CH_L || b == xed_pkg::CH_Q) begin
          ent_kind = (b == xed_pkg::CH_A) ? xed_pkg::KIND_AMP :
                     (b == xed_pkg::CH_G) ? xed_pkg::KIND_GT :
                     (b == xed_pkg::CH_L) ? xed_pkg::KIND_LT : xed_pkg::KIND_QUOT;
          name_idx = 1;
          dec_mode = xed_pkg::MODE_NAME;
        end else if (b == xed_pkg::CH_HASH) begin
          digit_cnt = 0;
          num_val = 8'h00;
          dec_mode = xed_pkg::MODE_NUM;
        end else begin
          emit(xed_pkg::CH_AMP);
          emit(b);
          dec_mode = xed_pkg::MODE_IDLE;
        end
      end
      xed_pkg::MODE_NAME: begin
        if (name_idx < s.len() && b == s[name_idx]) begin
          name_idx++;
          if (name_idx >= s.len()) begin
            emit(ent_glyph[int'(ent_kind)]);
            dec_mode = xed_pkg::MODE_IDLE;
          end
        end else begin
          flush_pending();
          idle_byte(b);
        end
      end
      default: begin
        if (b >= xed_pkg::CH_ZERO && b <= xed_pkg::CH_NINE) begin
          if (digit_cnt < MAX_DIG) begin
            digit_buf[digit_cnt] = 4'(b - xed_pkg::CH_ZERO);
            num_val = 8'((int'(num_val) * 10 + int'(b - xed_pkg::CH_ZERO)) & 255);
            digit_cnt++;
          end else begin
            // run too long: everything goes out literally, this digit included
            flush_pending();
            emit(b);
          end
        end else if (b == xed_pkg::CH_SEMI && digit_cnt > 0) begin
          emit(num_val);
          dec_mode = xed_pkg::MODE_IDLE;
        end else begin
          flush_pending();
          idle_byte(b);
        end
      end
    endcase
  endfunction

  function automatic void predict_step(input logic [7:0] b, input logic e);
    dec_out_t r;
    step_q.delete();
    if (!decode_on) begin
      flush_pending();
      emit(b);
    end else begin
      decode_byte(b);
    end
    if (e) flush_pending();
    if (step_q.size() > 0) begin
      r = step_q[step_q.size() - 1];
      r.run_last = 1'b1;
      r.text_end = e;
      step_q[step_q.size() - 1] = r;
    end
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  // output side: stall pattern
  always @(posedge clk) begin
    case (rx_mode)
      RX_FREE: m_tready <= 1'b1;
      RX_COIN: m_tready <= 1'($urandom_range(0, 1));
      default: begin
        if (rx_hold == 0) begin
          rx_hold = $urandom_range(1, 8);
          rx_stall = ~rx_stall;
        end else begin
          rx_hold--;
        end
        m_tready <= ~rx_stall;
      end
    endcase
  end

  // output side: compare each transfer with the oldest expectation
  always @(posedge clk) begin
    dec_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected output, exp none got %02h/%b/%b",
                 $time, m_tdata, m_tuser, m_tlast);
        mismatch_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (m_tdata !== want.data) begin
          $display("%0t: out_byte mismatch, exp %02h got %02h", $time, want.data, m_tdata);
          mismatch_cnt++;
        end
        if (m_tuser !== want.run_last) begin
          $display("%0t: run_last mismatch, exp %b got %b", $time, want.run_last, m_tuser);
          mismatch_cnt++;
        end
        if (m_tlast !== want.text_end) begin
          $display("%0t: text_end mismatch, exp %b got %b", $time, want.text_end, m_tlast);
          mismatch_cnt++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic e);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= e;
    do @(posedge clk); while (!s_tready);
    predict_step(b, e);
    if (tx_idle) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_str(input string s, input logic end_on_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], end_on_last && (i == s.len() - 1));
  endtask

  // stop sending and let every expected output drain
  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_decode(input logic v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    decode_on = v;
    cfg_wr_en <= 1'b0;
  endtask

  // random text: random bytes, well-formed named and numeric entities, and malformed ones
  task automatic random_text(input int n_bytes);
    int         sent;
    int         pick;
    int         k;
    int         n;
    string      s;
    logic [7:0] tok[$];
    sent = 0;
    while (sent < n_bytes) begin
      tok.delete();
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 3);
      s = ent_name[k];
      n = ($urandom_range(0, 3) == 0) ? MAX_DIG : $urandom_range(1, 3);
      if (pick < 30) begin
        repeat ($urandom_range(1, 6)) tok.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 55) begin
        tok.push_back(xed_pkg::CH_AMP);
        for (int i = 0; i < s.len(); i++) tok.push_back(s[i]);
      end else if (pick < 75) begin
        tok.push_back(xed_pkg::CH_AMP);
        tok.push_back(xed_pkg::CH_HASH);
        repeat (n) tok.push_back(xed_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        tok.push_back(xed_pkg::CH_SEMI);
      end else if (pick < 83) begin
        // name cut short by a random byte
        tok.push_back(xed_pkg::CH_AMP);
        for (int i = 0; i < $urandom_range(1, s.len() - 1); i++) tok.push_back(s[i]);
        tok.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        // digit run ended by some other byte, or overlong
        tok.push_back(xed_pkg::CH_AMP);
        tok.push_back(xed_pkg::CH_HASH);
        if ($urandom_range(0, 1)) begin
          repeat (MAX_DIG + 1) tok.push_back(xed_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end else begin
          repeat ($urandom_range(0, 3)) begin
            tok.push_back(xed_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
          end
          tok.push_back(8'($urandom_range(0, 255)));
        end
      end else if (pick < 95) begin
        tok.push_back(xed_pkg::CH_AMP);
        tok.push_back(8'($urandom_range(0, 255)));
      end else begin
        tok.push_back(xed_pkg::CH_AMP);
        tok.push_back(xed_pkg::CH_HASH);
        tok.push_back(xed_pkg::CH_SEMI);
      end
      foreach (tok[i]) send_byte(tok[i], $urandom_range(0, 24) == 0);
      sent += tok.size();
    end
  endtask

  task automatic test_directed();
    rx_mode = RX_COIN;
    tx_idle = 1'b1;
    set_decode(1'b1);
    send_str("&amp;", 1'b0);
    send_str("&qu", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_str("&&", 1'b0);
    send_str("&#;", 1'b0);
    send_str("&#123456789", 1'b0);
    send_str("&#-", 1'b0);
    send_str("&g", 1'b1);          // end of text in the middle of a name
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_decode_toggle();
    rx_mode = RX_FREE;
    send_str("&a", 1'b0);
    set_decode(1'b0);              // switched off mid-entity
    send_str("x&", 1'b0);
    set_decode(1'b1);
    send_str("&#7", 1'b1);
  endtask

  task automatic test_random_mixed();
    rx_mode = RX_COIN;
    tx_idle = 1'b1;
    random_text(140);
  endtask

  task automatic test_random_back_to_back();
    rx_mode = RX_FREE;
    tx_idle = 1'b0;
    random_text(80);
  endtask

  task automatic test_random_bypass();
    set_decode(1'b0);
    rx_mode = RX_BURST;
    tx_idle = 1'b1;
    random_text(50);
  endtask

  task automatic test_random_stalls();
    set_decode(1'b1);
    rx_mode = RX_BURST;
    tx_idle = 1'b1;
    random_text(50);
    drain();                       // hold input until the output is empty
    tx_idle = 1'b0;
    random_text(50);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_decode_toggle();
    test_random_mixed();
    test_random_back_to_back();
    test_random_bypass();
    test_random_stalls();
    drain();
    if (mismatch_cnt == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/xed_pkg.sv
rtl/core/xed_datapath.sv
rtl/core/xed_ctrl.sv
rtl/core/xml_entity_decoder.sv
dv/tb.sv
